// File: rtl/window_min_max_filter_core_assert.svh
// Assertion macros for the window min/max filter
`ifndef WINDOW_MIN_MAX_FILTER_CORE_ASSERT_SVH
`define WINDOW_MIN_MAX_FILTER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define WMM_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define WMM_ASSERT_NXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define WMM_ASSERT_IMP(name, ante, cons, msg)
`define WMM_ASSERT_NXT(name, ante, cons, msg)
`endif

`endif

// File: rtl/wmm_pkg.sv
`timescale 1ns / 1ps
package wmm_pkg;

   localparam int CFG_W = 12;

   localparam logic [1:0] REG_MODE   = 2'd0;
   localparam logic [1:0] REG_RADIUS = 2'd1;
   localparam logic [1:0] REG_WIDTH  = 2'd2;
   localparam logic [1:0] REG_HEIGHT = 2'd3;

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_FLUSH = 1'b1;

   localparam logic [7:0] PIX_MAX = 8'd255;
   localparam logic [7:0] PIX_MIN = 8'd0;

   typedef enum logic [2:0] {
      SC_IDLE = 3'b001,
      SC_RUN  = 3'b010,
      SC_DONE = 3'b100
   } scan_state_type;

   typedef struct packed {
      logic start;
      logic ack;
      logic is_min;
      logic last;
   } scan_ctl_type;

   typedef struct packed {
      logic idle;
      logic done;
   } scan_sts_type;

endpackage

// File: rtl/window_min_max_filter_core.sv
`timescale 1ns / 1ps
// channel   direction   handshake                  payload
// req       in          req_valid / req_stall      req_kind, req_pixel_in
// rsp       out         rsp_valid / rsp_stall      rsp_pixel_out, rsp_last_of_image
// csr       in          csr_valid / csr_ready      csr_index, csr_data
//
// A transfer that gives no result leaves the scan idle. A transfer that gives a result
// holds req_stall until its result moves to the output register; the scan reads rows * cols
// bytes, rows and cols being the clipped window size (up to (2r+1)^2): the window is read
// one byte a cycle through the single read port of the line store. The line store needs
// no clearing pass after reset. Reset is synchronous and clears control state only.
// A stalled result waits in the output register while the next item is taken.
module window_min_max_filter_core #(
   parameter int MAX_RADIUS = 15,
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_kind,
   input  logic [7:0]              req_pixel_in,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [7:0]              rsp_pixel_out,
   output logic                    rsp_last_of_image,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [1:0]              csr_index,
   input  logic [wmm_pkg::CFG_W-1:0] csr_data
);
   import wmm_pkg::*;

`include "window_min_max_filter_core_assert.svh"

   localparam int RING = 2 * MAX_RADIUS + 2;
   localparam int RIW  = $clog2(RING);
   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int ROWW = $clog2(MAX_HEIGHT);
   localparam int RW   = $clog2(MAX_RADIUS + 1);
   localparam int WW   = $clog2(MAX_WIDTH + 1);
   localparam int HW   = $clog2(MAX_HEIGHT + 1);
   localparam int NW   = $clog2(MAX_WIDTH * (MAX_HEIGHT + MAX_RADIUS + 1) + 1);

   // configuration
   logic             mode_ff, mode_in;
   logic [3:0]       radius_ff, radius_in;
   logic [CFG_W-1:0] width_ff, width_in;
   logic [CFG_W-1:0] height_ff, height_in;

   // position state
   logic [ROWW-1:0] in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [CW-1:0]   in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [RIW-1:0]  in_ring_ff, in_ring_in, out_ring_ff, out_ring_in;
   logic [NW-1:0]   n_ff, n_in;
   logic            draining_ff, draining_in;

   logic            rsp_valid_ff, rsp_valid_in;
   logic [7:0]      rsp_pixel_ff, rsp_pixel_in;
   logic            rsp_last_ff, rsp_last_in;

   logic [RW-1:0]   r_eff;
   logic [WW-1:0]   w_eff;
   logic [HW-1:0]   h_eff;
   logic [CW-1:0]   w_m1;
   logic [ROWW-1:0] h_m1;
   logic [NW-1:0]   delay;

   logic [ROWW-1:0] y0, y1;
   logic [CW-1:0]   x0, x1;
   logic [RIW-1:0]  dr, ring0;
   logic            out_last, in_last;

   logic            req_fire, csr_fire, is_flush, wr_en, emit;
   scan_ctl_type    ctl;
   scan_sts_type    sts;
   logic            rd_en;
   logic [RIW-1:0]  rd_ring;
   logic [CW-1:0]   rd_col;
   logic [7:0]      rd_data;
   logic [7:0]      res_pixel;
   logic            res_last;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;
   assign req_stall = !sts.idle;
   assign req_fire  = req_valid && !req_stall;
   assign is_flush  = (req_kind == KIND_FLUSH);

   // effective geometry
   always_comb begin
      if (32'(radius_ff) > MAX_RADIUS) begin
         r_eff = RW'(MAX_RADIUS);
      end else begin
         r_eff = RW'(radius_ff);
      end
      if (width_ff == '0) begin
         w_eff = WW'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = HW'(1);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         h_eff = HW'(MAX_HEIGHT);
      end else begin
         h_eff = HW'(height_ff);
      end
   end

   assign w_m1  = CW'(32'(w_eff) - 1);
   assign h_m1  = ROWW'(32'(h_eff) - 1);
   assign delay = NW'(32'(r_eff) * 32'(w_eff) + 32'(r_eff));

   // clipped window of the next output position
   always_comb begin
      if (32'(out_row_ff) >= 32'(r_eff)) begin
         y0 = out_row_ff - ROWW'(r_eff);
         dr = RIW'(r_eff);
      end else begin
         y0 = '0;
         dr = RIW'(out_row_ff);
      end
      if (32'(out_row_ff) + 32'(r_eff) < 32'(h_eff)) begin
         y1 = ROWW'(32'(out_row_ff) + 32'(r_eff));
      end else begin
         y1 = h_m1;
      end
      if (32'(out_col_ff) >= 32'(r_eff)) begin
         x0 = out_col_ff - CW'(r_eff);
      end else begin
         x0 = '0;
      end
      if (32'(out_col_ff) + 32'(r_eff) < 32'(w_eff)) begin
         x1 = CW'(32'(out_col_ff) + 32'(r_eff));
      end else begin
         x1 = w_m1;
      end
      if (out_ring_ff >= dr) begin
         ring0 = out_ring_ff - dr;
      end else begin
         ring0 = RIW'(32'(out_ring_ff) + RING - 32'(dr));
      end
   end

   assign out_last = (out_row_ff == h_m1) && (out_col_ff == w_m1);
   assign in_last  = (in_row_ff == h_m1) && (in_col_ff == w_m1);
   assign wr_en    = req_fire && !is_flush && !draining_ff;
   assign emit     = req_fire && (is_flush ? draining_ff : (!draining_ff && n_ff >= delay));

   assign ctl.start  = emit;
   assign ctl.is_min = mode_ff;
   assign ctl.last   = out_last;
   assign ctl.ack    = sts.done && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      mode_in     = mode_ff;
      radius_in   = radius_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      in_row_in   = in_row_ff;
      in_col_in   = in_col_ff;
      in_ring_in  = in_ring_ff;
      out_row_in  = out_row_ff;
      out_col_in  = out_col_ff;
      out_ring_in = out_ring_ff;
      n_in        = n_ff;
      draining_in = draining_ff;

      if (wr_en) begin
         n_in = n_ff + 1'b1;
         if (in_col_ff == w_m1) begin
            in_col_in  = '0;
            in_row_in  = in_row_ff + 1'b1;
            in_ring_in = (in_ring_ff == RIW'(RING - 1)) ? '0 : in_ring_ff + 1'b1;
         end else begin
            in_col_in = in_col_ff + 1'b1;
         end
         if (in_last) begin
            draining_in = 1'b1;
         end
      end

      if (emit) begin
         if (out_col_ff == w_m1) begin
            out_col_in  = '0;
            out_row_in  = out_row_ff + 1'b1;
            out_ring_in = (out_ring_ff == RIW'(RING - 1)) ? '0 : out_ring_ff + 1'b1;
         end else begin
            out_col_in = out_col_ff + 1'b1;
         end
      end

      // restart the image after its last output or on any register write
      if ((emit && out_last) || csr_fire) begin
         in_row_in   = '0;
         in_col_in   = '0;
         in_ring_in  = '0;
         out_row_in  = '0;
         out_col_in  = '0;
         out_ring_in = '0;
         n_in        = '0;
         draining_in = 1'b0;
      end

      if (csr_fire) begin
         unique case (csr_index)
            REG_MODE:   mode_in   = csr_data[0];
            REG_RADIUS: radius_in = csr_data[3:0];
            REG_WIDTH:  width_in  = csr_data;
            REG_HEIGHT: height_in = csr_data;
            default:    mode_in   = mode_ff;
         endcase
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_pixel_in = rsp_pixel_ff;
      rsp_last_in  = rsp_last_ff;
      if (ctl.ack) begin
         rsp_valid_in = 1'b1;
         rsp_pixel_in = res_pixel;
         rsp_last_in  = res_last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         radius_ff    <= 4'd7;
         width_ff     <= CFG_W'(640);
         height_ff    <= CFG_W'(480);
         in_row_ff    <= '0;
         in_col_ff    <= '0;
         in_ring_ff   <= '0;
         out_row_ff   <= '0;
         out_col_ff   <= '0;
         out_ring_ff  <= '0;
         n_ff         <= '0;
         draining_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         radius_ff    <= radius_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         in_row_ff    <= in_row_in;
         in_col_ff    <= in_col_in;
         in_ring_ff   <= in_ring_in;
         out_row_ff   <= out_row_in;
         out_col_ff   <= out_col_in;
         out_ring_ff  <= out_ring_in;
         n_ff         <= n_in;
         draining_ff  <= draining_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pixel_ff <= rsp_pixel_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pixel_out     = rsp_pixel_ff;
   assign rsp_last_of_image = rsp_last_ff;

   wmm_line_store #(
      .RING (RING),
      .RIW  (RIW),
      .CW   (CW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_ring (in_ring_ff),
      .wr_col  (in_col_ff),
      .wr_data (req_pixel_in),
      .rd_en   (rd_en),
      .rd_ring (rd_ring),
      .rd_col  (rd_col),
      .rd_data (rd_data)
   );

   wmm_scan #(
      .RING (RING),
      .RIW  (RIW),
      .CW   (CW),
      .ROWW (ROWW)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .y0        (y0),
      .y1        (y1),
      .ring0     (ring0),
      .x0        (x0),
      .x1        (x1),
      .rd_en     (rd_en),
      .rd_ring   (rd_ring),
      .rd_col    (rd_col),
      .rd_data   (rd_data),
      .sts       (sts),
      .res_pixel (res_pixel),
      .res_last  (res_last)
   );

   `WMM_ASSERT_IMP(a_write_not_draining, wr_en, !draining_ff, "line store written while draining")
   `WMM_ASSERT_NXT(a_start_busy, ctl.start, !sts.idle && req_stall, "window scan did not start")
   `WMM_ASSERT_NXT(a_done_held, sts.done && rsp_valid_ff && rsp_stall, sts.done, "result lost")
   `WMM_ASSERT_IMP(a_no_read_on_write, rd_en, !wr_en, "line store read and written together")

endmodule

// File: rtl/wmm_line_store.sv
`timescale 1ns / 1ps
module wmm_line_store #(
   parameter int RING = 32,
   parameter int RIW  = 5,
   parameter int CW   = 11
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [RIW-1:0]       wr_ring,
   input  logic [CW-1:0]        wr_col,
   input  logic [7:0]           wr_data,
   input  logic                 rd_en,
   input  logic [RIW-1:0]       rd_ring,
   input  logic [CW-1:0]        rd_col,
   output logic [7:0]           rd_data
);
   localparam int DEPTH = RING << CW;

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[{wr_ring, wr_col}] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[{rd_ring, rd_col}];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/wmm_scan.sv
`timescale 1ns / 1ps
module wmm_scan #(
   parameter int RING = 32,
   parameter int RIW  = 5,
   parameter int CW   = 11,
   parameter int ROWW = 11
) (
   input  logic                    clock,
   input  logic                    reset,
   input  wmm_pkg::scan_ctl_type   ctl,
   input  logic [ROWW-1:0]         y0,
   input  logic [ROWW-1:0]         y1,
   input  logic [RIW-1:0]          ring0,
   input  logic [CW-1:0]           x0,
   input  logic [CW-1:0]           x1,
   output logic                    rd_en,
   output logic [RIW-1:0]          rd_ring,
   output logic [CW-1:0]           rd_col,
   input  logic [7:0]              rd_data,
   output wmm_pkg::scan_sts_type   sts,
   output logic [7:0]              res_pixel,
   output logic                    res_last
);
   import wmm_pkg::*;

   scan_state_type state_ff, state_in;
   logic [ROWW-1:0] y_ff, y_in, y1_ff, y1_in;
   logic [RIW-1:0]  yr_ff, yr_in;
   logic [CW-1:0]   x_ff, x_in, x0_ff, x0_in, x1_ff, x1_in;
   logic            issue_ff, issue_in;
   logic            rd_vld_ff, rd_vld_in;
   logic            rd_end_ff, rd_end_in;
   logic [7:0]      acc_ff, acc_in;
   logic            is_min_ff, is_min_in;
   logic            last_ff, last_in;
   logic            step_end;

   assign rd_en   = issue_ff;
   assign rd_ring = yr_ff;
   assign rd_col  = x_ff;
   assign step_end = (x_ff == x1_ff) && (y_ff == y1_ff);

   always_comb begin
      state_in  = state_ff;
      y_in      = y_ff;
      y1_in     = y1_ff;
      yr_in     = yr_ff;
      x_in      = x_ff;
      x0_in     = x0_ff;
      x1_in     = x1_ff;
      issue_in  = issue_ff;
      acc_in    = acc_ff;
      is_min_in = is_min_ff;
      last_in   = last_ff;
      rd_vld_in = issue_ff;
      rd_end_in = issue_ff && step_end;

      // advance the read cursor row by row over the window
      if (issue_ff) begin
         if (x_ff == x1_ff) begin
            x_in = x0_ff;
            if (y_ff == y1_ff) begin
               issue_in = 1'b0;
            end else begin
               y_in  = y_ff + 1'b1;
               yr_in = (yr_ff == RIW'(RING - 1)) ? '0 : yr_ff + 1'b1;
            end
         end else begin
            x_in = x_ff + 1'b1;
         end
      end

      if (rd_vld_ff) begin
         if (is_min_ff ? (rd_data < acc_ff) : (rd_data > acc_ff)) begin
            acc_in = rd_data;
         end
      end

      unique case (state_ff)
         SC_IDLE: begin
            if (ctl.start) begin
               state_in  = SC_RUN;
               y_in      = y0;
               y1_in     = y1;
               yr_in     = ring0;
               x_in      = x0;
               x0_in     = x0;
               x1_in     = x1;
               issue_in  = 1'b1;
               is_min_in = ctl.is_min;
               last_in   = ctl.last;
               acc_in    = ctl.is_min ? PIX_MAX : PIX_MIN;
            end
         end
         SC_RUN: begin
            if (rd_vld_ff && rd_end_ff) begin
               state_in = SC_DONE;
            end
         end
         SC_DONE: begin
            if (ctl.ack) begin
               state_in = SC_IDLE;
            end
         end
         default: state_in = SC_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= SC_IDLE;
         issue_ff  <= 1'b0;
         rd_vld_ff <= 1'b0;
         rd_end_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         issue_ff  <= issue_in;
         rd_vld_ff <= rd_vld_in;
         rd_end_ff <= rd_end_in;
      end
   end

   always_ff @(posedge clock) begin
      y_ff      <= y_in;
      y1_ff     <= y1_in;
      yr_ff     <= yr_in;
      x_ff      <= x_in;
      x0_ff     <= x0_in;
      x1_ff     <= x1_in;
      acc_ff    <= acc_in;
      is_min_ff <= is_min_in;
      last_ff   <= last_in;
   end

   assign sts.idle  = (state_ff == SC_IDLE);
   assign sts.done  = (state_ff == SC_DONE);
   assign res_pixel = acc_ff;
   assign res_last  = last_ff;

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import wmm_pkg::*;

   localparam int RING_ROWS = 2 * 15 + 2;
   localparam int LINE_LEN  = 2048;
   localparam int SETTLE    = 1000;

   typedef struct {
      logic [7:0] pix;
      logic       last;
   } filt_result_type;

   typedef struct packed {
      bit          is_cfg;
      logic [1:0]  idx;
      logic [11:0] data;
      logic        kind;
      logic [7:0]  pix;
      bit          typed;
      logic [7:0]  exp_pix;
      logic        exp_last;
   } dir_row_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic req_kind;
   logic [7:0] req_pixel_in;
   logic rsp_valid;
   logic rsp_stall;
   logic [7:0] rsp_pixel_out;
   logic rsp_last_of_image;
   logic csr_valid;
   logic csr_ready;
   logic [1:0] csr_index;
   logic [CFG_W-1:0] csr_data;

   window_min_max_filter_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_kind(req_kind), .req_pixel_in(req_pixel_in),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_pixel_out(rsp_pixel_out), .rsp_last_of_image(rsp_last_of_image),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // filter state mirror
   logic [7:0] line_mem [RING_ROWS * LINE_LEN];
   int unsigned in_row, in_col, out_row, out_col;
   bit draining;
   logic cfg_mode;
   logic [3:0] cfg_radius;
   logic [11:0] cfg_width, cfg_height;

   filt_result_type window_q[$];
   int fails;
   int sent;
   bit calm;
   bit paused;
   bit held;
   int hold_left;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("window_min_max_filter_core test failed");
      $finish;
   end

   assign calm = (sent >= 100) && (sent < 260);

   function automatic int unsigned eff_width();
      if (cfg_width == 0) return 1;
      return (cfg_width > LINE_LEN) ? LINE_LEN : cfg_width;
   endfunction

   function automatic int unsigned eff_height();
      if (cfg_height == 0) return 1;
      return (cfg_height > 2048) ? 2048 : cfg_height;
   endfunction

   function automatic int unsigned ring_addr(int unsigned row, int unsigned col);
      return (row % RING_ROWS) * LINE_LEN + (col % LINE_LEN);
   endfunction

   task automatic restart_scan();
      in_row = 0; in_col = 0; out_row = 0; out_col = 0;
      draining = 0;
   endtask

   task automatic emit_window(output bit last);
      int unsigned r, w, h, r0, r1, c0, c1;
      logic [7:0] acc, v;
      filt_result_type res;
      r = cfg_radius; w = eff_width(); h = eff_height();
      r0 = (out_row >= r) ? out_row - r : 0;
      r1 = (out_row + r < h) ? out_row + r : h - 1;
      c0 = (out_col >= r) ? out_col - r : 0;
      c1 = (out_col + r < w) ? out_col + r : w - 1;
      acc = cfg_mode ? PIX_MAX : PIX_MIN;
      for (int unsigned y = r0; y <= r1; y++)
         for (int unsigned x = c0; x <= c1; x++) begin
            v = line_mem[ring_addr(y, x)];
            if (cfg_mode ? (v < acc) : (v > acc)) acc = v;
         end
      last = (out_row == h - 1) && (out_col == w - 1);
      res.pix = acc;
      res.last = last;
      window_q.push_back(res);
      if (out_col + 1 >= w) begin
         out_col = 0; out_row++;
      end else begin
         out_col++;
      end
   endtask

   task automatic predict_window(logic kind, logic [7:0] pix);
      int unsigned r, w, h, n;
      bit last, in_last;
      r = cfg_radius; w = eff_width(); h = eff_height();
      if (kind == KIND_FLUSH) begin
         if (draining) begin
            emit_window(last);
            if (last) restart_scan();
         end
         return;
      end
      if (draining) return;
      n = in_row * w + in_col;
      in_last = (in_row == h - 1) && (in_col == w - 1);
      line_mem[ring_addr(in_row, in_col)] = pix;
      if (in_col + 1 >= w) begin
         in_col = 0; in_row++;
      end else begin
         in_col++;
      end
      if (n >= r * w + r) begin
         emit_window(last);
         if (last) begin
            restart_scan();
            return;
         end
      end
      if (in_last) draining = 1;
   endtask

   task automatic send_item(logic kind, logic [7:0] pix);
      if (!paused && sent >= 500) begin
         // let the block empty out completely
         paused = 1;
         req_valid <= 1'b0;
         @(posedge clock);
         while (window_q.size() != 0) @(posedge clock);
      end
      while (!calm && $urandom_range(0, 99) < 26) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_pixel_in <= pix;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_window(kind, pix);
      sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (window_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [11:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_MODE:   cfg_mode = data[0];
         REG_RADIUS: cfg_radius = data[3:0];
         REG_WIDTH:  cfg_width = data;
         REG_HEIGHT: cfg_height = data;
         default: ;
      endcase
      restart_scan();
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [7:0] rand_pix();
      int unsigned sel;
      sel = $urandom_range(0, 7);
      if (sel == 0) return PIX_MIN;
      if (sel == 1) return PIX_MAX;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_image(int unsigned npix);
      for (int unsigned i = 0; i < npix; i++) begin
         if ($urandom_range(0, 19) == 0) send_item(KIND_FLUSH, 8'($urandom_range(0, 255)));
         send_item(KIND_PIXEL, rand_pix());
      end
      if ($urandom_range(0, 3) == 0) send_item(KIND_PIXEL, rand_pix());
      while (draining) send_item(KIND_FLUSH, 8'($urandom_range(0, 255)));
   endtask

   task automatic run_phase(logic md, logic [3:0] rad, logic [11:0] w, logic [11:0] h,
                            int unsigned images);
      int unsigned npix;
      wait_idle();
      write_reg(REG_MODE, {11'd0, md});
      write_reg(REG_RADIUS, {8'd0, rad});
      write_reg(REG_WIDTH, w);
      write_reg(REG_HEIGHT, h);
      npix = eff_width() * eff_height();
      for (int unsigned i = 0; i < images; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            // abandon the image partway
            send_image($urandom_range(0, npix - 1));
            return;
         end
         send_image(npix);
      end
   endtask

   // result side: random stall plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         held = 0;
         hold_left = 0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (!held && sent >= 300) begin
         held = 1;
         hold_left = 2000;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= (!calm && $urandom_range(0, 99) < 26);
      end
   end

   always @(posedge clock) begin
      filt_result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (window_q.size() == 0) begin
            $error("unexpected result transfer: pixel_out %0d", rsp_pixel_out);
            fails++;
         end else begin
            e = window_q.pop_front();
            if (rsp_pixel_out !== e.pix) begin
               $error("pixel_out: expected %0d, actual %0d", e.pix, rsp_pixel_out);
               fails++;
            end
            if (rsp_last_of_image !== e.last) begin
               $error("last_of_image: expected %0d, actual %0d", e.last, rsp_last_of_image);
               fails++;
            end
         end
      end
   end

   dir_row_type dir_tab [25];

   initial begin
      int unsigned before_n, mw, mh;
      filt_result_type got;
      dir_tab = '{
         '{1, REG_MODE,   12'd0, KIND_PIXEL, 8'd0,   0, 8'd0,   1'b0},
         '{1, REG_RADIUS, 12'd0, KIND_PIXEL, 8'd0,   0, 8'd0,   1'b0},
         '{1, REG_WIDTH,  12'd0, KIND_PIXEL, 8'd0,   0, 8'd0,   1'b0},
         '{1, REG_HEIGHT, 12'd0, KIND_PIXEL, 8'd0,   0, 8'd0,   1'b0},
         '{0, REG_MODE,   12'd0, KIND_PIXEL, 8'd255, 1, 8'd255, 1'b1},
         '{1, REG_MODE,   12'd1, KIND_PIXEL, 8'd0,   0, 8'd0,   1'b0},
         '{0, REG_MODE,   12'd0, KIND_PIXEL, 8'd0,   1, 8'd0,   1'b1},
         '{0, REG_MODE,   12'd0, KIND_FLUSH, 8'hA5,  0, 8'd0,   1'b0},
         '{1, REG_RADIUS, 12'd1, KIND_PIXEL, 8'd0,   0, 8'd0,   1'b0},
         '{1, REG_WIDTH,  12'd3, KIND_PIXEL, 8'd0,   0, 8'd0,   1'b0},
         '{1, REG_HEIGHT, 12'd2, KIND_PIXEL, 8'd0,   0, 8'd0,   1'b0},
         '{1, REG_MODE,   12'd0, KIND_PIXEL, 8'd0,   0, 8'd0,   1'b0},
         '{0, REG_MODE,   12'd0, KIND_PIXEL, 8'd7,   0, 8'd0,   1'b0},
         '{0, REG_MODE,   12'd0, KIND_FLUSH, 8'h5A,  0, 8'd0,   1'b0},
         '{0, REG_MODE,   12'd0, KIND_PIXEL, 8'd255, 0, 8'd0,   1'b0},
         '{0, REG_MODE,   12'd0, KIND_PIXEL, 8'd0,   0, 8'd0,   1'b0},
         '{0, REG_MODE,   12'd0, KIND_PIXEL, 8'd1,   0, 8'd0,   1'b0},
         '{0, REG_MODE,   12'd0, KIND_PIXEL, 8'd2,   0, 8'd0,   1'b0},
         '{0, REG_MODE,   12'd0, KIND_PIXEL, 8'd3,   0, 8'd0,   1'b0},
         '{0, REG_MODE,   12'd0, KIND_PIXEL, 8'd9,   0, 8'd0,   1'b0},
         '{0, REG_MODE,   12'd0, KIND_FLUSH, 8'h00,  0, 8'd0,   1'b0},
         '{0, REG_MODE,   12'd0, KIND_FLUSH, 8'hFF,  0, 8'd0,   1'b0},
         '{0, REG_MODE,   12'd0, KIND_FLUSH, 8'h00,  0, 8'd0,   1'b0},
         '{0, REG_MODE,   12'd0, KIND_FLUSH, 8'hFF,  0, 8'd0,   1'b0},
         '{0, REG_MODE,   12'd0, KIND_FLUSH, 8'h00,  0, 8'd0,   1'b0}
      };
      fails = 0; sent = 0; paused = 0;
      reset = 1'b1;
      req_valid = 1'b0; req_kind = KIND_PIXEL; req_pixel_in = 8'd0;
      csr_valid = 1'b0; csr_index = REG_MODE; csr_data = '0;
      cfg_mode = 1'b0; cfg_radius = 4'd7; cfg_width = 12'd640; cfg_height = 12'd480;
      restart_scan();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_tab[i]) begin
         if (dir_tab[i].is_cfg) begin
            wait_idle();
            write_reg(dir_tab[i].idx, dir_tab[i].data);
         end else begin
            before_n = window_q.size();
            send_item(dir_tab[i].kind, dir_tab[i].pix);
            if (dir_tab[i].typed) begin
               if (window_q.size() != before_n + 1) begin
                  $error("pixel_out: expected a result, none predicted");
                  fails++;
               end else begin
                  got = window_q[$];
                  if (got.pix !== dir_tab[i].exp_pix || got.last !== dir_tab[i].exp_last) begin
                     $error("pixel_out: expected %0d, actual %0d", dir_tab[i].exp_pix, got.pix);
                     fails++;
                  end
               end
            end
         end
      end

      // zero-sized frames and a window larger than the frame
      run_phase(1'b1, 4'd15, 12'd0, 12'd3, 1);
      run_phase(1'b0, 4'd0, 12'd3, 12'd0, 1);
      run_phase(1'b0, 4'd15, 12'd5, 12'd4, 2);

      while (sent < 750) begin
         mw = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 8);
         mh = $urandom_range(1, 6);
         run_phase(1'($urandom_range(0, 1)),
                   ($urandom_range(0, 9) == 0) ? 4'd15 : 4'($urandom_range(0, 3)),
                   12'(mw), 12'(mh), $urandom_range(1, 3));
      end

      wait_idle();
      if (fails == 0)
         $display("window_min_max_filter_core test passed");
      else
         $display("window_min_max_filter_core test failed");
      $finish;
   end

endmodule
